FILE: src/isq_pkg.sv
// Shared types and constants for the instrument status and error queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package isq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CODE_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int QCOUNT_W    = 5;
   localparam int CSR_IDX_W   = 1;

   localparam logic signed [CODE_W-1:0] OVERFLOW_CODE = -16'sd350;

   localparam logic [BYTE_W-1:0] EV_COMPLETE  = 8'h01;
   localparam logic [BYTE_W-1:0] EV_QUERY     = 8'h04;
   localparam logic [BYTE_W-1:0] EV_DEVICE    = 8'h08;
   localparam logic [BYTE_W-1:0] EV_EXECUTION = 8'h10;
   localparam logic [BYTE_W-1:0] EV_COMMAND   = 8'h20;

   localparam logic [BYTE_W-1:0] STB_QUEUE   = 8'h04;
   localparam logic [BYTE_W-1:0] STB_EVENT   = 8'h20;
   localparam logic [BYTE_W-1:0] STB_SUMMARY = 8'h40;
   localparam logic [BYTE_W-1:0] STB_SUM_EXCL = 8'hBF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EVENT_ENABLE   = 1'd0,
      CSR_SERVICE_ENABLE = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_READ_CLEAR = 3'd2,
      OP_READ_STB   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_COMPLETE   = 3'd5
   } op_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [CODE_W-1:0] error_code;
   } req_type;

   typedef struct packed {
      logic signed [CODE_W-1:0] popped_code;
      logic [BYTE_W-1:0]        event_status;
      logic [BYTE_W-1:0]        status_byte;
      logic [QCOUNT_W-1:0]      queue_count;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } qcmd_type;

   function automatic logic [BYTE_W-1:0] class_bit(logic signed [CODE_W-1:0] c);
      logic [BYTE_W-1:0] bits;
      bits = '0;
      if (c <= -16'sd100 && c > -16'sd200) bits = EV_COMMAND;
      else if (c <= -16'sd200 && c > -16'sd300) bits = EV_EXECUTION;
      else if (c <= -16'sd300 && c > -16'sd400) bits = EV_DEVICE;
      else if (c <= -16'sd400 && c > -16'sd500) bits = EV_QUERY;
      return bits;
   endfunction

endpackage

`default_nettype wire

FILE: src/isq_queue.sv
// Circular error queue: register store, oldest pointer and fill count.
// Depends on isq_pkg for depth, widths and the command struct.
`default_nettype none

module isq_queue
   import isq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire qcmd_type                 cmd,
   input  wire logic signed [CODE_W-1:0] push_code,
   output logic signed [CODE_W-1:0]      pop_code,
   output logic [CNT_W-1:0]              count_next
);

   logic [CODE_W-1:0] store_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]  oldest_ff;
   logic [IDX_W-1:0]  oldest_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W:0]    tail_sum;
   logic [IDX_W:0]    last_sum;
   logic [IDX_W-1:0]  wr_idx;
   logic [CODE_W-1:0] wr_data;
   logic              wr_en;
   logic              full;
   logic              empty;

   always_comb begin
      full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      tail_sum = {1'b0, oldest_ff} + (IDX_W + 1)'(count_ff);
      if (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (IDX_W + 1)'(QUEUE_DEPTH);
      end
      last_sum = {1'b0, oldest_ff} + (IDX_W + 1)'(QUEUE_DEPTH - 1);
      if (last_sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
         last_sum = last_sum - (IDX_W + 1)'(QUEUE_DEPTH);
      end

      oldest_in = oldest_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_idx    = tail_sum[IDX_W-1:0];
      wr_data   = push_code;
      pop_code  = '0;

      if (cmd.clear) begin
         oldest_in = '0;
         count_in  = '0;
      end else if (cmd.push) begin
         wr_en = 1'b1;
         if (full) begin
            wr_idx  = last_sum[IDX_W-1:0];
            wr_data = OVERFLOW_CODE;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.pop && !empty) begin
         pop_code = store_ff[oldest_ff];
         count_in = count_ff - 1'b1;
         if (oldest_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_ff + 1'b1;
         end
      end
      count_next = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/isq_status.sv
// Event status register, enable masks and status byte summary logic.
// Depends on isq_pkg for operation codes, register indexes and bit masks.
`default_nettype none

module isq_status
   import isq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [BYTE_W-1:0]        csr_data,
   input  wire logic                     valid,
   input  wire op_type                   operation,
   input  wire logic signed [CODE_W-1:0] error_code,
   input  wire logic [CNT_W-1:0]         count_next,
   output logic [BYTE_W-1:0]             event_seen,
   output logic [BYTE_W-1:0]             status_byte
);

   logic [BYTE_W-1:0] event_ff;
   logic [BYTE_W-1:0] event_in;
   logic [BYTE_W-1:0] eem_ff;
   logic [BYTE_W-1:0] sem_ff;

   always_comb begin
      event_in   = event_ff;
      event_seen = event_ff;
      if (valid) begin
         case (operation)
            OP_PUSH: begin
               event_in   = event_ff | class_bit(error_code);
               event_seen = event_in;
            end
            OP_COMPLETE: begin
               event_in   = event_ff | EV_COMPLETE;
               event_seen = event_in;
            end
            OP_READ_CLEAR, OP_CLEAR: begin
               event_in = '0;
            end
            default: begin
               event_in = event_ff;
            end
         endcase
      end

      status_byte = '0;
      if (count_next != '0) status_byte = status_byte | STB_QUEUE;
      if ((event_in & eem_ff) != '0) status_byte = status_byte | STB_EVENT;
      if ((status_byte & sem_ff & STB_SUM_EXCL) != '0) begin
         status_byte = status_byte | STB_SUMMARY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff <= '0;
         eem_ff   <= '0;
         sem_ff   <= '0;
      end else begin
         event_ff <= event_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_EVENT_ENABLE:   eem_ff <= csr_data;
               CSR_SERVICE_ENABLE: sem_ff <= csr_data;
               default:            eem_ff <= eem_ff;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/instrument_status_error_queue.sv
// Top level of the instrument status and error queue.
// Depends on isq_pkg, isq_queue and isq_status.
//
// A request is taken at a rising clock edge with start high; busy is always
// low, so one request can be taken in every cycle. Each request carries an
// operation and an error code: push an error, pop the oldest error, read and
// clear the event status register, read the status byte, clear the status,
// or mark operation complete. Codes 6 and 7 act as a status byte read.
// Every request yields exactly one response, shown on rsp_data for one cycle
// with rsp_valid high. The request register loads at the request edge, the
// queue and status logic load the response register at the next edge, and
// the receiver takes the response from that register on rsp_data.
// Throughput is one request per cycle, set by the single pass from the
// request register to the response register. The receiver cannot stall,
// so nothing is held back. The enable masks are written through the csr_
// port at any edge with csr_we high. Reset clears the queue pointers, the
// count, the event register, both masks and all valid flags; the error store
// itself is not cleared, since an entry is only read after it is written.
`default_nettype none

module instrument_status_error_queue
   import isq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_data
);

   logic                     req_valid_ff;
   req_type                  req_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   qcmd_type                 qcmd;
   logic signed [CODE_W-1:0] pop_code;
   logic [CNT_W-1:0]         count_next;
   logic [BYTE_W-1:0]        event_seen;
   logic [BYTE_W-1:0]        status_byte;

   assign busy = 1'b0;

   always_comb begin
      qcmd = '0;
      if (req_valid_ff) begin
         unique case (req_ff.operation)
            OP_PUSH:  qcmd.push  = 1'b1;
            OP_POP:   qcmd.pop   = 1'b1;
            OP_CLEAR: qcmd.clear = 1'b1;
            default:  qcmd = '0;
         endcase
      end
   end

   isq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (qcmd),
      .push_code  (req_ff.error_code),
      .pop_code   (pop_code),
      .count_next (count_next)
   );

   isq_status u_status (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .valid       (req_valid_ff),
      .operation   (req_ff.operation),
      .error_code  (req_ff.error_code),
      .count_next  (count_next),
      .event_seen  (event_seen),
      .status_byte (status_byte)
   );

   always_comb begin
      rsp_in.popped_code  = pop_code;
      rsp_in.event_status = event_seen;
      rsp_in.status_byte  = status_byte;
      rsp_in.queue_count  = QCOUNT_W'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for instrument_status_error_queue: directed error classes and
// queue overflow, then random traffic under several enable mask settings.
// Depends on isq_pkg and the instrument_status_error_queue RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isq_pkg::*;

   localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_data;

   logic signed [CODE_W-1:0] model_store [QUEUE_DEPTH];
   int unsigned              model_oldest;
   int unsigned              model_count;
   logic [BYTE_W-1:0]        model_events;
   logic [BYTE_W-1:0]        model_event_mask;
   logic [BYTE_W-1:0]        model_service_mask;

   rsp_type pending_responses [$];
   rsp_type expected_response;
   int      mismatch_count = 0;
   int      burst_left = 0;
   int      idle_count = 0;

   instrument_status_error_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [BYTE_W-1:0] error_class_event(logic signed [CODE_W-1:0] code);
      int magnitude;
      magnitude = -int'(code);
      case (magnitude / 100)
         1: return EV_COMMAND;
         2: return EV_EXECUTION;
         3: return EV_DEVICE;
         4: return EV_QUERY;
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [CODE_W-1:0] random_error_code();
      int magnitude;
      case ($urandom_range(0, 3))
         0: return CODE_W'($urandom);
         1: begin
            magnitude = $urandom_range(100, 499);
            return CODE_W'(-magnitude);
         end
         default: begin
            magnitude = $urandom_range(0, 650);
            return CODE_W'(-magnitude);
         end
      endcase
   endfunction

   task automatic predict_status(input req_type request);
      rsp_type outcome;
      outcome = '0;
      case (request.operation)
         OP_PUSH: begin
            model_events |= error_class_event(request.error_code);
            if (model_count == QUEUE_DEPTH) begin
               model_store[(model_oldest + QUEUE_DEPTH - 1) % QUEUE_DEPTH] = OVERFLOW_CODE;
            end else begin
               model_store[(model_oldest + model_count) % QUEUE_DEPTH] = request.error_code;
               model_count++;
            end
            outcome.event_status = model_events;
         end
         OP_POP: begin
            if (model_count != 0) begin
               outcome.popped_code = model_store[model_oldest];
               model_oldest = (model_oldest + 1) % QUEUE_DEPTH;
               model_count--;
            end
            outcome.event_status = model_events;
         end
         OP_READ_CLEAR: begin
            outcome.event_status = model_events;
            model_events = '0;
         end
         OP_CLEAR: begin
            outcome.event_status = model_events;
            model_count = 0;
            model_oldest = 0;
            model_events = '0;
         end
         OP_COMPLETE: begin
            model_events |= EV_COMPLETE;
            outcome.event_status = model_events;
         end
         default: begin
            outcome.event_status = model_events;
         end
      endcase
      if (model_count != 0) outcome.status_byte |= STB_QUEUE;
      if ((model_events & model_event_mask) != 0) outcome.status_byte |= STB_EVENT;
      if ((outcome.status_byte & model_service_mask & STB_SUM_EXCL) != 0)
         outcome.status_byte |= STB_SUMMARY;
      outcome.queue_count = QCOUNT_W'(model_count);
      pending_responses.insert(pending_responses.size(), outcome);
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic issue_request(input logic [2:0] op, input logic signed [CODE_W-1:0] code);
      req_type request;
      int gap;
      request.operation = op_type'(op);
      request.error_code = code;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_data <= request;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_status(request);
   endtask

   task automatic issue_random(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         issue_request(OP_PUSH, random_error_code());
      end else if (roll < push_pct + (100 - push_pct) / 2) begin
         issue_request(OP_POP, CODE_W'($urandom));
      end else begin
         case ($urandom_range(0, 10))
            0, 1, 2: issue_request(OP_READ_CLEAR, CODE_W'($urandom));
            3, 4, 5: issue_request(OP_READ_STB, CODE_W'($urandom));
            6: issue_request(OP_CLEAR, CODE_W'($urandom));
            7, 8: issue_request(OP_COMPLETE, CODE_W'($urandom));
            9: issue_request(OP_SPARE_LOW, CODE_W'($urandom));
            default: issue_request(OP_SPARE_HIGH, CODE_W'($urandom));
         endcase
      end
   endtask

   task automatic write_mask(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == CSR_EVENT_ENABLE) model_event_mask = value;
      else model_service_mask = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_error_classes();
      logic signed [CODE_W-1:0] edge_codes [13];
      edge_codes = '{-16'sd99, -16'sd100, -16'sd199, -16'sd200, -16'sd299, -16'sd300,
                     -16'sd399, -16'sd400, -16'sd499, -16'sd500, 16'sd0, 16'sh7FFF,
                     16'sh8000};
      issue_request(OP_POP, 16'shFFFF);
      issue_request(OP_READ_STB, '0);
      wait_idle();
      write_mask(CSR_EVENT_ENABLE, 8'hFF);
      write_mask(CSR_SERVICE_ENABLE, 8'hFF);
      foreach (edge_codes[i]) issue_request(OP_PUSH, edge_codes[i]);
      issue_request(OP_READ_CLEAR, '0);
      issue_request(OP_COMPLETE, '0);
      issue_request(OP_READ_STB, '0);
      issue_request(OP_SPARE_LOW, 16'sh5A5A);
      issue_request(OP_SPARE_HIGH, 16'shA5A5);
      issue_request(OP_POP, '0);
      issue_request(OP_CLEAR, '0);
      issue_request(OP_POP, '0);
      wait_idle();
   endtask

   task automatic test_queue_overflow();
      issue_request(OP_CLEAR, '0);
      repeat (QUEUE_DEPTH + 2) issue_request(OP_PUSH, random_error_code());
      issue_request(OP_READ_STB, '0);
      repeat (QUEUE_DEPTH + 1) issue_request(OP_POP, '0);
      wait_idle();
   endtask

   task automatic test_random_traffic(input logic [BYTE_W-1:0] event_mask,
                                      input logic [BYTE_W-1:0] service_mask,
                                      input int push_pct, input int count);
      wait_idle();
      write_mask(CSR_EVENT_ENABLE, event_mask);
      write_mask(CSR_SERVICE_ENABLE, service_mask);
      repeat (count) issue_random(push_pct);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response with no request pending: %p", rsp_data));
         end else begin
            expected_response = pending_responses[0];
            pending_responses.delete(0);
            if (rsp_data.popped_code !== expected_response.popped_code)
               report_mismatch($sformatf("popped_code %0d, expected %0d",
                                         rsp_data.popped_code, expected_response.popped_code));
            if (rsp_data.event_status !== expected_response.event_status)
               report_mismatch($sformatf("event_status %h, expected %h",
                                         rsp_data.event_status, expected_response.event_status));
            if (rsp_data.status_byte !== expected_response.status_byte)
               report_mismatch($sformatf("status_byte %h, expected %h",
                                         rsp_data.status_byte, expected_response.status_byte));
            if (rsp_data.queue_count !== expected_response.queue_count)
               report_mismatch($sformatf("queue_count %0d, expected %0d",
                                         rsp_data.queue_count, expected_response.queue_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("instrument_status_error_queue regression: fail");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      model_oldest = 0;
      model_count = 0;
      model_events = '0;
      model_event_mask = '0;
      model_service_mask = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_error_classes();
      test_queue_overflow();
      test_random_traffic(8'h00, 8'h00, 45, 60);
      test_random_traffic(8'hFF, 8'hFF, 45, 60);
      test_random_traffic(8'hFF, 8'h00, 65, 60);
      test_random_traffic(8'h00, 8'hFF, 35, 60);
      test_random_traffic(BYTE_W'($urandom), BYTE_W'($urandom), 55, 80);
      test_random_traffic(BYTE_W'($urandom), BYTE_W'($urandom), 50, 80);
      wait_idle();
      if (mismatch_count == 0) begin
         $display("instrument_status_error_queue regression: pass");
      end else begin
         $display("instrument_status_error_queue regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/isq_pkg.sv
src/isq_queue.sv
src/isq_status.sv
src/instrument_status_error_queue.sv
verif/testbench.sv
